@@ sv/nsv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_pkg
// shared types, character codes and lookup functions for the sentence
// validator
// ----------------------------------------------------------------------------
package nsv_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam int unsigned TOKEN_DEPTH = 6;
    localparam int unsigned TAIL_DEPTH  = 4;

    localparam logic [2:0] TOKEN_LEN_MAX = 3'd7;
    localparam logic [2:0] LINE_LEN_MAX  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_COMMA  = 3'd1;
    localparam logic [2:0] ST_BAD_START = 3'd2;
    localparam logic [2:0] ST_NO_SUM    = 3'd3;
    localparam logic [2:0] ST_BAD_SUM   = 3'd4;

    // sentence kinds
    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_RMC     = 4'd1;
    localparam logic [3:0] KIND_GGA     = 4'd2;
    localparam logic [3:0] KIND_GSA     = 4'd3;
    localparam logic [3:0] KIND_GSV     = 4'd4;
    localparam logic [3:0] KIND_GLL     = 4'd5;
    localparam logic [3:0] KIND_VTG     = 4'd6;
    localparam logic [3:0] KIND_TXT     = 4'd7;
    localparam logic [3:0] KIND_PUBX    = 4'd8;

    // constellations
    localparam logic [2:0] CONS_UNKNOWN = 3'd0;
    localparam logic [2:0] CONS_GN      = 3'd1;
    localparam logic [2:0] CONS_GP      = 3'd2;
    localparam logic [2:0] CONS_GL      = 3'd3;
    localparam logic [2:0] CONS_GA      = 3'd4;
    localparam logic [2:0] CONS_GB      = 3'd5;
    localparam logic [2:0] CONS_GI      = 3'd6;
    localparam logic [2:0] CONS_IN      = 3'd7;

    typedef struct packed {
        logic [7:0]                  running_xor;
        logic [7:0]                  xor_at_last_star;
        logic                        star_seen;
        logic [7:0]                  first_byte;
        logic                        comma_seen;
        logic                        comma_at_start;
        logic [TOKEN_DEPTH-1:0][7:0] token_chars;
        logic [2:0]                  token_length;
        logic [TAIL_DEPTH-1:0][7:0]  tail_bytes;   // [0] is the newest
        logic [2:0]                  line_length;
    } t_line_state;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] sentence_kind;
        logic [2:0] constellation;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } t_result;

    // {valid, value} of one ascii hex digit, either case
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [3:0] kind_code(input logic [23:0] w);
        logic [3:0] k;
        unique case (w)
            "RMC":   k = KIND_RMC;
            "GGA":   k = KIND_GGA;
            "GSA":   k = KIND_GSA;
            "GSV":   k = KIND_GSV;
            "GLL":   k = KIND_GLL;
            "VTG":   k = KIND_VTG;
            "TXT":   k = KIND_TXT;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] talker_code(input logic [15:0] w);
        logic [2:0] t;
        unique case (w)
            "GN":    t = CONS_GN;
            "GP":    t = CONS_GP;
            "GL":    t = CONS_GL;
            "GA":    t = CONS_GA;
            "GB":    t = CONS_GB;
            "GI":    t = CONS_GI;
            "IN":    t = CONS_IN;
            default: t = CONS_UNKNOWN;
        endcase
        return t;
    endfunction

endpackage

@@ sv/nsv_line_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_line_track
// per-line running state: xor, star and comma tracking, token capture and
// the last four bytes; cleared at every line end
// ----------------------------------------------------------------------------
module nsv_line_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output nsv_pkg::t_line_state o_state
);
    import nsv_pkg::*;

    t_line_state r_state;
    t_line_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_step) begin
            if (i_byte == CH_LF) begin
                n_state = '0;
            end else begin
                if (i_byte == CH_STAR) begin
                    n_state.xor_at_last_star = r_state.running_xor;
                    n_state.star_seen        = 1'b1;
                end
                if (r_state.line_length == 3'd0) begin
                    n_state.first_byte = i_byte;
                    if (i_byte == CH_COMMA) begin
                        n_state.comma_at_start = 1'b1;
                    end
                end else begin
                    n_state.running_xor = r_state.running_xor ^ i_byte;
                end

                if (!r_state.comma_seen) begin
                    if (i_byte == CH_COMMA) begin
                        n_state.comma_seen = 1'b1;
                    end else begin
                        for (int i = 0; i < TOKEN_DEPTH; i++) begin
                            if (r_state.token_length == 3'(i)) begin
                                n_state.token_chars[i] = i_byte;
                            end
                        end
                        if (r_state.token_length != TOKEN_LEN_MAX) begin
                            n_state.token_length = r_state.token_length + 3'd1;
                        end
                    end
                end

                n_state.tail_bytes = {r_state.tail_bytes[TAIL_DEPTH-2:0], i_byte};
                if (r_state.line_length != LINE_LEN_MAX) begin
                    n_state.line_length = r_state.line_length + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

@@ sv/nsv_line_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_line_eval
// line end checks: comma, start, checksum framing and compare, then sentence
// kind and talker lookup
// ----------------------------------------------------------------------------
module nsv_line_eval (
    input  nsv_pkg::t_line_state i_state,
    output nsv_pkg::t_result     o_result
);
    import nsv_pkg::*;

    logic       has_cr;
    logic [2:0] eff_len;
    logic [7:0] third_last;
    logic [7:0] hex_hi_ch;
    logic [7:0] hex_lo_ch;
    logic [4:0] hex_hi;
    logic [4:0] hex_lo;
    logic       star_framed;
    logic       hex_ok;
    logic [7:0] rx_sum;
    logic [7:0] calc_sum;
    logic       is_pubx;

    always_comb begin
        has_cr  = (i_state.line_length != 3'd0) && (i_state.tail_bytes[0] == CH_CR);
        eff_len = i_state.line_length - {2'b00, has_cr};
        // with a trailing cr everything moves one byte further back
        third_last = has_cr ? i_state.tail_bytes[3] : i_state.tail_bytes[2];
        hex_hi_ch  = has_cr ? i_state.tail_bytes[2] : i_state.tail_bytes[1];
        hex_lo_ch  = has_cr ? i_state.tail_bytes[1] : i_state.tail_bytes[0];
        hex_hi     = hex_digit(hex_hi_ch);
        hex_lo     = hex_digit(hex_lo_ch);

        star_framed = (eff_len >= 3'd3) && (third_last == CH_STAR);
        hex_ok      = hex_hi[4] && hex_lo[4];
        rx_sum      = {hex_hi[3:0], hex_lo[3:0]};
        calc_sum    = i_state.star_seen ? i_state.xor_at_last_star : 8'h00;

        o_result = '0;
        priority if (!i_state.comma_seen || i_state.comma_at_start) begin
            o_result.status = ST_NO_COMMA;
        end else if (i_state.first_byte != CH_DOLLAR) begin
            o_result.status = ST_BAD_START;
        end else if (!star_framed) begin
            o_result.status = ST_NO_SUM;
        end else begin
            o_result.computed_sum = calc_sum;
            if (hex_ok) begin
                o_result.received_sum = rx_sum;
                o_result.status       = (calc_sum == rx_sum) ? ST_OK : ST_BAD_SUM;
            end else begin
                o_result.status = ST_BAD_SUM;
            end
        end

        is_pubx = (i_state.token_length == 3'd5) && (i_state.token_chars[0] == CH_DOLLAR)
                  && ({i_state.token_chars[1], i_state.token_chars[2],
                       i_state.token_chars[3], i_state.token_chars[4]} == "PUBX");

        if (o_result.status == ST_OK) begin
            if (is_pubx) begin
                o_result.sentence_kind = KIND_PUBX;
            end else begin
                if (i_state.token_length >= 3'd6) begin
                    o_result.sentence_kind = kind_code({i_state.token_chars[3],
                        i_state.token_chars[4], i_state.token_chars[5]});
                end
                if (i_state.token_length >= 3'd3) begin
                    o_result.constellation = talker_code({i_state.token_chars[1],
                        i_state.token_chars[2]});
                end
            end
        end
    end

endmodule

@@ sv/nmea_sentence_validator_core.sv @@
`timescale 1ns / 1ps
// result: an accepted lf beat goes from the input register into the result register
// throughput: one byte per cycle; a held result only stalls the input once an lf
//   beat is waiting in the input register
// reset: synchronous active-low i_rst_n clears the line state and both valid flags
// ----------------------------------------------------------------------------
// nmea_sentence_validator_core
// byte stream sentence checker: input register, line state tracking, line end
// evaluation into a result register
// ----------------------------------------------------------------------------
module nmea_sentence_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_status,
    output logic [3:0] o_sentence_kind,
    output logic [2:0] o_constellation,
    output logic [7:0] o_computed_sum,
    output logic [7:0] o_received_sum
);
    import nsv_pkg::*;

    logic        r_in_valid;
    logic        n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_res_valid;
    logic        n_res_valid;
    t_result     r_result;
    t_result     line_result;
    t_line_state line_state;
    logic        in_fire;
    logic        step;
    logic        step_lf;

    // a buffered lf may only move on when the result slot frees up
    assign step    = r_in_valid && ((r_in_byte != CH_LF) || !r_res_valid || i_res_ready);
    assign step_lf = step && (r_in_byte == CH_LF);
    assign o_ready = !r_in_valid || step;
    assign in_fire = i_valid && o_ready;

    nsv_line_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_state (line_state)
    );

    nsv_line_eval u_eval (
        .i_state  (line_state),
        .o_result (line_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
        n_res_valid = r_res_valid;
        if (step_lf) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_data_byte;
        end
        if (step_lf) begin
            r_result <= line_result;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_status        = r_result.status;
    assign o_sentence_kind = r_result.sentence_kind;
    assign o_constellation = r_result.constellation;
    assign o_computed_sum  = r_result.computed_sum;
    assign o_received_sum  = r_result.received_sum;

    a_class_only_when_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != ST_OK)
        |-> (o_sentence_kind == KIND_UNKNOWN && o_constellation == CONS_UNKNOWN))
        else $error("kind or talker set on a failed line");

    a_sums_only_when_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != ST_OK && o_status != ST_BAD_SUM)
        |-> (o_computed_sum == 8'h00 && o_received_sum == 8'h00))
        else $error("checksum fields set on an unframed line");

    a_ok_means_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status == ST_OK) |-> (o_computed_sum == o_received_sum))
        else $error("ok status with mismatched checksum");

    a_held_byte_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input register lost its beat");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_lf && r_res_valid) |-> i_res_ready)
        else $error("result register overwritten before it was taken");

endmodule
